// ===== hdl/rtk_pkg.sv =====
package rtk_pkg;

  localparam int CW      = 6;
  localparam int ID_W    = 48;
  localparam int NUM_W   = 31;
  localparam int TIME_W  = 40;
  localparam int SS_W    = 26;
  localparam int CFG_W   = 9;
  localparam int IN_DW   = 152;
  localparam int OUT_DW  = 152;

  localparam int HOURS_PER_DAY = 24;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_DAY  = HOURS_PER_DAY * SECS_PER_HOUR;
  localparam logic [CFG_W-1:0] STALE_DAYS_RST = 9'd7;

  localparam logic [2:0] OP_MERGE  = 3'd0;
  localparam logic [2:0] OP_DROP   = 3'd1;
  localparam logic [2:0] OP_EXPIRE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_BAD_ID   = 3'd2;
  localparam logic [2:0] ST_NOTIFIED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NUM_W-1:0]  number;
    logic signed [7:0] primary;
    logic signed [15:0] keyword;
    logic              taken;
    logic              fresh;
    logic [TIME_W-1:0] seen_at;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan;
    logic rd_en;
    logic commit;
    logic move;
    logic emit_plain;
    logic emit_row;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          skip;
    logic          match;
    logic          out_free;
    logic [CW-1:0] cnt;
  } sts_t;

  // true when a ranks strictly below b
  function automatic logic ent_worse(ent_t a, ent_t b);
    logic res;
    if (a.primary != b.primary) begin
      res = ($signed(a.primary) < $signed(b.primary));
    end else if (a.seen_at != b.seen_at) begin
      res = (a.seen_at < b.seen_at);
    end else begin
      res = (a.id > b.id);
    end
    return res;
  endfunction

endpackage

// ===== hdl/ranked_top_k_table.sv =====
// Ranked top-k table: keeps up to DEPTH entries ranked by primary score
// (high first), then first-seen time (late first), then id (low first).
// in_tuser selects the request: merge (upsert by id, evicting the worst
// entry when full and the newcomer ranks strictly better), drop by id,
// expire entries whose first-seen time is at least stale_days old, clear
// all fresh marks, or read the table out best first. Every request but a
// non-empty readout answers with one word; a readout gives one word per
// entry with tlast on the final one. Entries sit in one RAM with a single
// read and a single write port, and every request that needs a scan walks
// it one slot a cycle; a readout rescans the table to find each next-best
// entry. A result word held back by out_tready stalls the next one. One
// request is worked at a time; in_tready is high only while the block is
// idle and out of reset.
module ranked_top_k_table
  import rtk_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // id[47:0], item_number[78:48], primary_score[86:79],
  // keyword_score[102:87], taken_flag[103], already_notified[104],
  // now_time[144:105], zero fill
  input  logic [IN_DW-1:0]    in_tdata,
  // req_type[2:0]
  input  logic [2:0]          in_tuser,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,   // stale_days
  output logic                out_tvalid,
  input  logic                out_tready,
  // count[5:0], out_id[53:6], out_number[84:54], out_primary_score[92:85],
  // out_keyword_score[108:93], out_taken[109], out_fresh[110],
  // out_seen_at[150:111], zero fill
  output logic [OUT_DW-1:0]   out_tdata,
  // status[2:0]
  output logic [2:0]          out_tuser,
  output logic                out_tlast
);

  cmd_t                     cmd;
  sts_t                     sts;
  logic [$clog2(DEPTH)-1:0] rd_addr;

  rtk_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  rtk_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== hdl/rtk_ram.sv =====
module rtk_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rtk_ctrl.sv =====
module rtk_ctrl
  import rtk_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  sts_t                     sts,
  output cmd_t                     cmd,
  output logic [$clog2(DEPTH)-1:0] rd_addr
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_DRAIN  = 9'b000001000,
    S_COMMIT = 9'b000010000,
    S_RDLAST = 9'b000100000,
    S_MOVE   = 9'b001000000,
    S_EMITP  = 9'b010000000,
    S_EMITE  = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] cnt_m1;
  logic          needs_scan;

  assign cnt_m1 = sts.cnt - CW'(1);
  assign needs_scan = (sts.cnt != '0) &&
                      ((sts.op == OP_MERGE && !sts.skip) || sts.op == OP_DROP ||
                       sts.op == OP_EXPIRE || sts.op == OP_CLEAR || sts.op == OP_READ);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    cmd       = '0;
    rd_addr   = idx_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (needs_scan) begin
          cmd.scan_clr = 1'b1;
          idx_nxt      = '0;
          k_nxt        = '0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        if (CW'(idx_r) == cnt_m1) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = (sts.op == OP_READ) ? S_EMITE : S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.op == OP_DROP && sts.match) begin
          state_nxt = S_RDLAST;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_EMITP;
        end
      end
      S_RDLAST: begin
        cmd.rd_en = 1'b1;
        rd_addr   = cnt_m1[AW-1:0];
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_EMITP;
      end
      S_EMITP: begin
        if (sts.out_free) begin
          cmd.emit_plain = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMITE: begin
        if (sts.out_free) begin
          cmd.emit_row = 1'b1;
          cmd.last     = (k_r == cnt_m1);
          if (k_r == cnt_m1) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_clr = 1'b1;
            k_nxt        = k_r + CW'(1);
            idx_nxt      = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== hdl/rtk_dp.sv =====
module rtk_dp
  import rtk_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2:0]               in_tuser,
  input  logic [IN_DW-1:0]         in_tdata,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  cmd_t                     cmd,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sts_t                     sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DW-1:0]        out_tdata,
  output logic [2:0]               out_tuser,
  output logic                     out_tlast
);

  localparam int AW = $clog2(DEPTH);

  logic [2:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [NUM_W-1:0]  num_r;
  logic [7:0]        prim_r;
  logic [15:0]       kw_r;
  logic              taken_r, notif_r;
  logic [TIME_W-1:0] now_r;

  logic [CW-1:0]     cnt_r;
  logic [SS_W-1:0]   stale_secs_r;

  logic              d_vld_r;
  logic [AW-1:0]     d_idx_r;
  logic              match_r;
  logic [AW-1:0]     match_slot_r;
  logic [TIME_W-1:0] match_fs_r;
  ent_t              worst_r;
  logic [AW-1:0]     worst_slot_r;
  ent_t              best_r, prev_r;
  logic              have_best_r, prev_vld_r;
  logic [CW-1:0]     keep_r;
  logic [2:0]        res_st_r;
  logic [CW-1:0]     res_cnt_r;

  logic              out_valid_r;
  logic [2:0]        out_st_r;
  logic [CW-1:0]     out_cnt_r;
  ent_t              out_ent_r;
  logic              out_last_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ent_t              wr_data, rd_data, new_ent, upd_ent;
  logic              keep_ok, rd_cand, rd_take, skip;
  logic [2:0]        res_st_nxt;
  logic [CW-1:0]     res_cnt_nxt, cnt_nxt;

  rtk_ram #(.W(ENT_W), .D(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign skip = (id_r == '0) || notif_r;

  always_comb begin
    new_ent = '{id: id_r, number: num_r, primary: prim_r, keyword: kw_r,
                taken: taken_r, fresh: 1'b1, seen_at: now_r};
    upd_ent = new_ent;
    upd_ent.seen_at = match_fs_r;
  end

  // entry survives expiry while seen_at + window > now
  assign keep_ok = ({1'b0, rd_data.seen_at} + (TIME_W+1)'(stale_secs_r)) >
                   {1'b0, now_r};
  assign rd_cand = !prev_vld_r || ent_worse(rd_data, prev_r);
  assign rd_take = rd_cand && (!have_best_r || ent_worse(best_r, rd_data));

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = d_idx_r;
    wr_data     = rd_data;
    res_st_nxt  = ST_DONE;
    res_cnt_nxt = cnt_r;
    cnt_nxt     = cnt_r;
    if (d_vld_r && op_r == OP_EXPIRE && keep_ok) begin
      wr_en   = 1'b1;
      wr_addr = keep_r[AW-1:0];
    end
    if (d_vld_r && op_r == OP_CLEAR) begin
      wr_en         = 1'b1;
      wr_data.fresh = 1'b0;
    end
    if (cmd.commit) begin
      case (op_r)
        OP_MERGE: begin
          if (skip) begin
            res_st_nxt = (id_r == '0) ? ST_BAD_ID : ST_NOTIFIED;
          end else if (match_r) begin
            wr_en      = 1'b1;
            wr_addr    = match_slot_r;
            wr_data    = upd_ent;
            res_st_nxt = ST_UPDATED;
          end else if (cnt_r < CW'(DEPTH)) begin
            wr_en       = 1'b1;
            wr_addr     = cnt_r[AW-1:0];
            wr_data     = new_ent;
            cnt_nxt     = cnt_r + CW'(1);
            res_cnt_nxt = cnt_nxt;
            res_st_nxt  = ST_ADDED;
          end else if (ent_worse(worst_r, new_ent)) begin
            wr_en      = 1'b1;
            wr_addr    = worst_slot_r;
            wr_data    = new_ent;
            res_st_nxt = ST_ADDED;
          end else begin
            res_st_nxt = ST_REJECTED;
          end
        end
        OP_DROP: res_cnt_nxt = '0;
        OP_EXPIRE: begin
          cnt_nxt     = keep_r;
          res_cnt_nxt = cnt_r - keep_r;
        end
        default: res_cnt_nxt = cnt_r;
      endcase
    end
    if (cmd.move) begin
      wr_en       = 1'b1;
      wr_addr     = match_slot_r;
      cnt_nxt     = cnt_r - CW'(1);
      res_cnt_nxt = CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      stale_secs_r <= SS_W'(STALE_DAYS_RST * SECS_PER_DAY);
      d_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      d_vld_r <= cmd.scan;
      if (cfg_wr_en) begin
        stale_secs_r <= SS_W'(cfg_wr_data * SS_W'(SECS_PER_DAY));
      end
      if (cmd.emit_plain || cmd.emit_row) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx_r <= rd_addr;
    if (cmd.load) begin
      op_r        <= in_tuser;
      id_r        <= in_tdata[47:0];
      num_r       <= in_tdata[78:48];
      prim_r      <= in_tdata[86:79];
      kw_r        <= in_tdata[102:87];
      taken_r     <= in_tdata[103];
      notif_r     <= in_tdata[104];
      now_r       <= in_tdata[144:105];
      match_r     <= 1'b0;
      keep_r      <= '0;
      prev_vld_r  <= 1'b0;
      have_best_r <= 1'b0;
    end
    if (cmd.scan_clr) begin
      match_r     <= 1'b0;
      keep_r      <= '0;
      have_best_r <= 1'b0;
    end
    if (d_vld_r) begin
      if ((op_r == OP_MERGE || op_r == OP_DROP) && !match_r && rd_data.id == id_r) begin
        match_r      <= 1'b1;
        match_slot_r <= d_idx_r;
        match_fs_r   <= rd_data.seen_at;
      end
      if (d_idx_r == '0 || ent_worse(rd_data, worst_r)) begin
        worst_r      <= rd_data;
        worst_slot_r <= d_idx_r;
      end
      if (op_r == OP_EXPIRE && keep_ok) begin
        keep_r <= keep_r + CW'(1);
      end
      if (op_r == OP_READ && rd_take) begin
        best_r      <= rd_data;
        have_best_r <= 1'b1;
      end
    end
    if (cmd.commit || cmd.move) begin
      res_st_r  <= res_st_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
    if (cmd.emit_plain) begin
      out_st_r   <= res_st_r;
      out_cnt_r  <= res_cnt_r;
      out_ent_r  <= '0;
      out_last_r <= 1'b1;
    end
    if (cmd.emit_row) begin
      out_st_r   <= ST_DONE;
      out_cnt_r  <= cnt_r;
      out_ent_r  <= best_r;
      out_last_r <= cmd.last;
      prev_r     <= best_r;
      prev_vld_r <= 1'b1;
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.skip     = skip;
    sts.match    = match_r;
    sts.out_free = !out_valid_r || out_tready;
    sts.cnt      = cnt_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_ent_r.seen_at, out_ent_r.fresh, out_ent_r.taken,
                       out_ent_r.keyword, out_ent_r.primary, out_ent_r.number,
                       out_ent_r.id, out_cnt_r};

endmodule

// ===== dv/ranked_top_k_table_test.sv =====
// Self-checking bench for ranked_top_k_table. A directed table of requests
// walks the corner cases first, then random traffic runs under several
// stale_days settings. Every accepted request goes through a local model
// of the table; every output word is matched against the oldest
// expected word in order.
module ranked_top_k_table_test;
  import rtk_pkg::*;

  localparam int TBL_DEPTH = 32;
  localparam int N_RANDOM  = 360;
  localparam int MAX_CYC   = 3000000;

  // one request as the sender sees it
  typedef struct {
    logic [2:0]         op;
    logic [ID_W-1:0]    id;
    logic [NUM_W-1:0]   number;
    logic signed [7:0]  primary;
    logic signed [15:0] keyword;
    logic               taken;
    logic               notified;
    logic [TIME_W-1:0]  now;
  } req_t;

  // one output word
  typedef struct {
    logic [2:0]    status;
    logic [CW-1:0] count;
    ent_t          ent;
    logic          last;
  } word_t;

  // directed row: request plus an optional hand-typed status and count
  typedef struct {
    req_t          req;
    bit            typed;
    logic [2:0]    status;
    logic [CW-1:0] count;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata;
  logic [2:0] in_tuser;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  ranked_top_k_table #(.DEPTH(TBL_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // local copy of the table
  ent_t          tbl[TBL_DEPTH];
  int            tbl_count;
  logic [CFG_W-1:0] stale_days;

  word_t  pending_words[$];
  int     n_errors;
  int     n_cycles;
  bit     burst_in;   // stretches with no sender gaps
  bit     burst_out;  // stretches with no receiver stalls
  logic [TIME_W-1:0] clock_secs;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > MAX_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // strict rank order: a sits below b
  function automatic bit below(ent_t a, ent_t b);
    if (a.primary != b.primary) return a.primary < b.primary;
    if (a.seen_at != b.seen_at) return a.seen_at < b.seen_at;
    return a.id > b.id;
  endfunction

  function automatic word_t plain_word(logic [2:0] st, int cnt);
    word_t w;
    w = '{default: '0};
    w.status = st;
    w.count = cnt[CW-1:0];
    w.last = 1'b1;
    return w;
  endfunction

  // applies one request to the table and queues the words it yields
  task automatic model_table(req_t r);
    ent_t nw, t;
    int slot, worst, keep, dropped, i, k;
    longint cutoff;
    word_t w;
    slot = -1;
    case (r.op)
      OP_MERGE: begin
        if (r.id == '0) begin
          pending_words.push_back(plain_word(ST_BAD_ID, tbl_count));
        end else if (r.notified) begin
          pending_words.push_back(plain_word(ST_NOTIFIED, tbl_count));
        end else begin
          for (i = 0; i < tbl_count; i++)
            if (slot < 0 && tbl[i].id == r.id) slot = i;
          if (slot >= 0) begin
            tbl[slot].number = r.number;
            tbl[slot].primary = r.primary;
            tbl[slot].keyword = r.keyword;
            tbl[slot].taken = r.taken;
            tbl[slot].fresh = 1'b1;
            pending_words.push_back(plain_word(ST_UPDATED, tbl_count));
          end else begin
            nw = '{id: r.id, number: r.number, primary: r.primary,
                   keyword: r.keyword, taken: r.taken, fresh: 1'b1,
                   seen_at: r.now};
            if (tbl_count < TBL_DEPTH) begin
              tbl[tbl_count] = nw;
              tbl_count++;
              pending_words.push_back(plain_word(ST_ADDED, tbl_count));
            end else begin
              worst = 0;
              for (i = 1; i < tbl_count; i++)
                if (below(tbl[i], tbl[worst])) worst = i;
              if (below(tbl[worst], nw)) begin
                tbl[worst] = nw;
                pending_words.push_back(plain_word(ST_ADDED, tbl_count));
              end else begin
                pending_words.push_back(plain_word(ST_REJECTED, tbl_count));
              end
            end
          end
        end
      end
      OP_DROP: begin
        for (i = 0; i < tbl_count; i++)
          if (slot < 0 && tbl[i].id == r.id) slot = i;
        if (slot >= 0) begin
          for (k = slot; k + 1 < tbl_count; k++) tbl[k] = tbl[k + 1];
          tbl_count--;
        end
        pending_words.push_back(plain_word(ST_DONE, slot >= 0 ? 1 : 0));
      end
      OP_EXPIRE: begin
        // signed cutoff, may go negative
        cutoff = longint'(r.now) - longint'(stale_days) * SECS_PER_DAY;
        keep = 0;
        dropped = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (longint'(tbl[i].seen_at) > cutoff) begin
            tbl[keep] = tbl[i];
            keep++;
          end else begin
            dropped++;
          end
        end
        tbl_count = keep;
        pending_words.push_back(plain_word(ST_DONE, dropped));
      end
      OP_CLEAR: begin
        for (i = 0; i < tbl_count; i++) tbl[i].fresh = 1'b0;
        pending_words.push_back(plain_word(ST_DONE, tbl_count));
      end
      OP_READ: begin
        if (tbl_count == 0) begin
          pending_words.push_back(plain_word(ST_DONE, 0));
        end else begin
          for (i = 1; i < tbl_count; i++)
            for (k = i; k > 0 && below(tbl[k - 1], tbl[k]); k--) begin
              t = tbl[k - 1];
              tbl[k - 1] = tbl[k];
              tbl[k] = t;
            end
          for (i = 0; i < tbl_count; i++) begin
            w.status = ST_DONE;
            w.count = tbl_count[CW-1:0];
            w.ent = tbl[i];
            w.last = (i + 1 == tbl_count);
            pending_words.push_back(w);
          end
        end
      end
      default: pending_words.push_back(plain_word(ST_DONE, tbl_count));
    endcase
  endtask

  // tvalid stays up after the accepting edge and drops only before a gap
  task automatic send_req(req_t r);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {7'b0, r.now, r.notified, r.taken, r.keyword, r.primary,
                 r.number, r.id};
    do @(posedge clk); while (!in_tready);
    model_table(r);
  endtask

  // waits for the table to go quiet, then writes stale_days
  task automatic set_stale_days(logic [CFG_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stale_days = v;
  endtask

  function automatic req_t make_req(logic [2:0] op, logic [ID_W-1:0] id,
                                    logic signed [7:0] p, logic nt,
                                    logic [TIME_W-1:0] now);
    req_t r;
    r.op = op;
    r.id = id;
    r.number = NUM_W'($urandom);
    r.primary = p;
    r.keyword = 16'($urandom);
    r.taken = 1'($urandom_range(0, 1));
    r.notified = nt;
    r.now = now;
    return r;
  endfunction

  function automatic req_t random_req();
    int pick;
    logic [2:0] op;
    logic [ID_W-1:0] id;
    logic signed [7:0] p;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 60) op = OP_MERGE;
    else if (pick < 70) op = OP_DROP;
    else if (pick < 78) op = OP_EXPIRE;
    else if (pick < 85) op = OP_CLEAR;
    else if (pick < 95) op = OP_READ;
    else op = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 5) id = '0;
    else if (pick < 85) id = ID_W'($urandom_range(1, 44));
    else id = ID_W'({$urandom, $urandom});
    // a narrow score band forces ties onto first-seen time and id
    p = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) - 8'sd1 : 8'($urandom);
    clock_secs = clock_secs + TIME_W'($urandom_range(0, 40000));
    now = ($urandom_range(0, 19) == 0) ? TIME_W'({$urandom, $urandom}) : clock_secs;
    if ($urandom_range(0, 3) == 0) now = clock_secs - TIME_W'($urandom_range(0, 200));
    return make_req(op, id, p, $urandom_range(0, 9) == 0, now);
  endfunction

  // receiver: random stalls, in-order compare
  initial begin
    word_t want;
    word_t got;
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      got.status = out_tuser;
      got.count = out_tdata[5:0];
      got.ent.id = out_tdata[53:6];
      got.ent.number = out_tdata[84:54];
      got.ent.primary = out_tdata[92:85];
      got.ent.keyword = out_tdata[108:93];
      got.ent.taken = out_tdata[109];
      got.ent.fresh = out_tdata[110];
      got.ent.seen_at = out_tdata[150:111];
      got.last = out_tlast;
      if (pending_words.size() == 0) begin
        report("unexpected word", got.status, 0);
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.count !== want.count) report("count", got.count, want.count);
        if (got.ent.id !== want.ent.id) report("id", got.ent.id, want.ent.id);
        if (got.ent.number !== want.ent.number)
          report("number", got.ent.number, want.ent.number);
        if (got.ent.primary !== want.ent.primary)
          report("primary", got.ent.primary, want.ent.primary);
        if (got.ent.keyword !== want.ent.keyword)
          report("keyword", got.ent.keyword, want.ent.keyword);
        if (got.ent.taken !== want.ent.taken)
          report("taken", got.ent.taken, want.ent.taken);
        if (got.ent.fresh !== want.ent.fresh)
          report("fresh", got.ent.fresh, want.ent.fresh);
        if (got.ent.seen_at !== want.ent.seen_at)
          report("seen_at", got.ent.seen_at, want.ent.seen_at);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    int i, j;
    logic [CFG_W-1:0] settings[6];
    n_errors = 0;
    burst_in = 1'b0;
    burst_out = 1'b0;
    clock_secs = 40'd1000000;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_MERGE;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tbl_count = 0;
    stale_days = STALE_DAYS_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty-table answers, bad id, notified skip,
    // extremes of every field, update keeps first-seen, negative cutoff
    rows.push_back('{make_req(OP_READ, 48'd9, 0, 0, 0), 1, ST_DONE, 0});
    rows.push_back('{make_req(OP_DROP, 48'd9, 0, 0, 0), 1, ST_DONE, 0});
    rows.push_back('{make_req(OP_EXPIRE, 48'd0, 0, 0, 40'd0), 1, ST_DONE, 0});
    rows.push_back('{make_req(OP_CLEAR, 48'd0, 0, 0, 0), 1, ST_DONE, 0});
    rows.push_back('{make_req(3'd7, 48'd0, 0, 0, 0), 1, ST_DONE, 0});
    rows.push_back('{make_req(OP_MERGE, 48'd0, 0, 0, 0), 1, ST_BAD_ID, 0});
    rows.push_back('{make_req(OP_MERGE, 48'd0, 0, 1, 0), 1, ST_BAD_ID, 0});
    rows.push_back('{make_req(OP_MERGE, 48'd5, 0, 1, 0), 1, ST_NOTIFIED, 0});
    rw = '{make_req(OP_MERGE, 48'd5, 8'sd127, 0, '1), 1, ST_ADDED, 1};
    rw.req.number = '1;
    rw.req.keyword = 16'sh7fff;
    rw.req.taken = 1'b1;
    rows.push_back(rw);
    rw = '{make_req(OP_MERGE, 48'd5, -8'sd128, 0, 40'd3), 1, ST_UPDATED, 1};
    rw.req.number = '0;
    rw.req.keyword = -16'sh8000;
    rw.req.taken = 1'b0;
    rows.push_back(rw);
    rows.push_back('{make_req(OP_MERGE, '1, -8'sd128, 0, 40'd0), 1, ST_ADDED, 2});
    rows.push_back('{make_req(OP_MERGE, 48'd1, -8'sd128, 0, 40'd0), 1, ST_ADDED, 3});
    rows.push_back('{make_req(OP_MERGE, 48'd2, 8'sd0, 0, 40'd500), 1, ST_ADDED, 4});
    rows.push_back('{make_req(OP_READ, 48'd0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_req(OP_CLEAR, 48'd0, 0, 0, 0), 1, ST_DONE, 4});
    rows.push_back('{make_req(OP_READ, 48'd0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_req(OP_EXPIRE, 48'd0, 0, 0, 40'd100), 1, ST_DONE, 0});
    rows.push_back('{make_req(OP_DROP, 48'd2, 0, 0, 0), 1, ST_DONE, 1});
    rows.push_back('{make_req(OP_DROP, 48'd2, 0, 0, 0), 1, ST_DONE, 0});
    rows.push_back('{make_req(3'd5, 48'd0, 0, 0, 0), 1, ST_DONE, 3});
    rows.push_back('{make_req(3'd6, 48'd0, 0, 0, 0), 1, ST_DONE, 3});
    rows.push_back('{make_req(OP_EXPIRE, 48'd0, 0, 0, 40'd1000000), 0, 0, 0});
    rows.push_back('{make_req(OP_READ, 48'd0, 0, 0, 0), 0, 0, 0});

    // a typed row yields one word, the newest one in the queue
    foreach (rows[r]) begin
      send_req(rows[r].req);
      if (rows[r].typed) begin
        if (pending_words[$].status !== rows[r].status)
          report("table status", pending_words[$].status, rows[r].status);
        if (pending_words[$].count !== rows[r].count)
          report("table count", pending_words[$].count, rows[r].count);
      end
    end

    // random phases, each under its own stale window
    settings = '{9'd1, 9'd365, 9'd0, 9'd511, 9'($urandom_range(2, 60)), 9'd7};
    for (i = 0; i < 6; i++) begin
      set_stale_days(settings[i]);
      for (j = 0; j < N_RANDOM / 6; j++) begin
        if (j % 20 == 0) begin
          burst_in = ($urandom_range(0, 3) == 0);
          burst_out = ($urandom_range(0, 3) == 0);
        end
        send_req(random_req());
      end
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rtk_pkg.sv
hdl/rtk_ram.sv
hdl/rtk_ctrl.sv
hdl/rtk_dp.sv
hdl/ranked_top_k_table.sv
dv/ranked_top_k_table_test.sv
